// File: rtl/core/rbb_pkg.sv
// Shared types and constants of the RGB box blur stream unit.
// No dependencies; rbb_ctrl, rbb_datapath, the top level and the testbench import it.
package rbb_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 2'd3;

    localparam logic [11:0] RST_FRAME_WIDTH  = 12'd1280;
    localparam logic [11:0] RST_FRAME_HEIGHT = 12'd720;
    localparam logic [3:0]  RST_RADIUS       = 4'd1;
    localparam logic        RST_MODE         = 1'b0;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic MODE_MEAN = 1'b0;
    localparam logic MODE_RMS  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_ACC,
        S_FLUSH,
        S_DLOAD,
        S_DIV,
        S_SQRT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic win_start;
        logic win_step;
        logic div_start;
        logic div_step;
        logic sq_start;
        logic sq_step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic res_ready;
        logic win_last;
        logic div_done;
        logic sq_done;
        logic out_busy;
        logic mode;
    } t_dp_sts;

endpackage

// File: rtl/core/rbb_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module rbb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/rbb_ctrl.sv
// Sequencer of the box blur: steps one item through store and, when a result
// is due, window sum, division, optional root and output. Depends on rbb_pkg.
module rbb_ctrl import rbb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.res_ready) begin
                    o_cmd.win_start = 1'b1;
                    n_state         = S_ACC;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ACC: begin
                o_cmd.win_step = 1'b1;
                if (i_sts.win_last) begin
                    n_state = S_FLUSH;
                end
            end
            // last read data is summed here
            S_FLUSH: n_state = S_DLOAD;
            S_DLOAD: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    if (i_sts.mode == MODE_RMS) begin
                        o_cmd.sq_start = 1'b1;
                        n_state        = S_SQRT;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_SQRT: begin
                if (i_sts.sq_done) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.sq_step = 1'b1;
                end
            end
            S_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: rtl/core/rbb_datapath.sv
// Datapath of the box blur: configuration, frame counters, line store,
// window accumulator, serial divider, serial square root and output register.
// Depends on rbb_pkg and rbb_ram.
module rbb_datapath import rbb_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int MAX_RADIUS = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_cmd,
    input  logic [7:0]            i_red,
    input  logic [7:0]            i_green,
    input  logic [7:0]            i_blue,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_out_red,
    output logic [7:0]            o_out_green,
    output logic [7:0]            o_out_blue,
    output logic                  o_frame_last,
    input  t_dp_cmd               i_cmd_dp,
    output t_dp_sts               o_sts
);

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int HW      = $clog2(MAX_HEIGHT);
    localparam int HHW     = $clog2(MAX_HEIGHT + 1);
    localparam int RING    = 2 * MAX_RADIUS + 2;
    localparam int RW      = $clog2(RING);
    localparam int WIN     = 2 * MAX_RADIUS + 1;
    localparam int RADW    = $clog2(WIN);
    localparam int CNT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int THR_W   = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);
    localparam int AREA_W  = $clog2(WIN * WIN + 1);
    localparam int SUM_W   = $clog2(WIN * WIN * 65025 + 1);
    localparam int SQ_STEPS = (SUM_W + 1) / 2;
    localparam int SQW     = SUM_W + 1;
    localparam int DCW     = $clog2(SUM_W + 1);
    localparam int SCW     = $clog2(SQ_STEPS + 1);
    localparam int PW      = ((HW > CW) ? HW : CW) + RADW + 2;
    localparam int AW      = $clog2(RING << CW);
    localparam int CMP_W   = CNT_W + THR_W;

    // configuration
    logic [11:0] r_cfg_w;
    logic [11:0] r_cfg_h;
    logic [3:0]  r_cfg_r;
    logic        r_cfg_mode;
    logic        cfg_hit;

    assign cfg_hit = i_cfg_wr_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= RST_FRAME_WIDTH;
            r_cfg_h    <= RST_FRAME_HEIGHT;
            r_cfg_r    <= RST_RADIUS;
            r_cfg_mode <= RST_MODE;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_cfg_w    <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_cfg_h    <= i_cfg_data;
                CFG_RADIUS:       r_cfg_r    <= i_cfg_data[3:0];
                CFG_MODE:         r_cfg_mode <= i_cfg_data[0];
                default:          r_cfg_mode <= r_cfg_mode;
            endcase
        end
    end

    // effective values after clamping
    logic [WW-1:0]     w_eff;
    logic [HHW-1:0]    h_eff;
    logic [RADW-1:0]   r_eff;
    logic [CNT_W-1:0]  total;
    logic [THR_W-1:0]  thr;
    logic [RADW:0]     side;
    logic [AREA_W-1:0] area;

    always_comb begin
        if (r_cfg_w == 12'd0) begin
            w_eff = WW'(1);
        end else if ({1'b0, r_cfg_w} > 13'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_cfg_w);
        end
        if (r_cfg_h == 12'd0) begin
            h_eff = HHW'(1);
        end else if ({1'b0, r_cfg_h} > 13'(MAX_HEIGHT)) begin
            h_eff = HHW'(MAX_HEIGHT);
        end else begin
            h_eff = HHW'(r_cfg_h);
        end
        if ({2'b00, r_cfg_r} > 6'(MAX_RADIUS)) begin
            r_eff = RADW'(MAX_RADIUS);
        end else begin
            r_eff = RADW'(r_cfg_r);
        end
    end

    assign total = CNT_W'(w_eff) * CNT_W'(h_eff);
    assign thr   = THR_W'(r_eff) * THR_W'(w_eff) + THR_W'(r_eff) + THR_W'(1);
    assign side  = {r_eff, 1'b1};
    assign area  = AREA_W'(side) * AREA_W'(side);

    // frame counters and positions
    logic [CNT_W-1:0] r_in_cnt;
    logic [CNT_W-1:0] r_out_cnt;
    logic [CW-1:0]    r_wr_col;
    logic [RW-1:0]    r_wr_ring;
    logic [CW-1:0]    r_x;
    logic [HW-1:0]    r_y;
    logic [RW-1:0]    r_y_ring;
    logic             full;
    logic             do_write;
    logic [CNT_W-1:0] lead;
    logic             is_last;

    assign full     = (r_in_cnt >= total);
    assign do_write = i_cmd_dp.accept && (i_cmd == CMD_PIXEL) && !full;
    assign lead     = r_in_cnt - r_out_cnt;
    assign is_last  = (r_out_cnt == total - CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit || (i_cmd_dp.emit && is_last)) begin
            r_in_cnt  <= '0;
            r_out_cnt <= '0;
            r_wr_col  <= '0;
            r_wr_ring <= '0;
            r_x       <= '0;
            r_y       <= '0;
            r_y_ring  <= '0;
        end else begin
            if (do_write) begin
                r_in_cnt <= r_in_cnt + CNT_W'(1);
                if (WW'(r_wr_col) == w_eff - WW'(1)) begin
                    r_wr_col  <= '0;
                    r_wr_ring <= (r_wr_ring == RW'(RING - 1)) ? '0 : r_wr_ring + RW'(1);
                end else begin
                    r_wr_col <= r_wr_col + CW'(1);
                end
            end
            if (i_cmd_dp.emit) begin
                r_out_cnt <= r_out_cnt + CNT_W'(1);
                if (WW'(r_x) == w_eff - WW'(1)) begin
                    r_x      <= '0;
                    r_y      <= r_y + HW'(1);
                    r_y_ring <= (r_y_ring == RW'(RING - 1)) ? '0 : r_y_ring + RW'(1);
                end else begin
                    r_x <= r_x + CW'(1);
                end
            end
        end
    end

    // window walk
    logic [RADW-1:0]     r_wi;
    logic [RADW-1:0]     r_wj;
    logic [RW-1:0]       r_wring;
    logic [RADW-1:0]     two_r;
    logic signed [PW-1:0] py;
    logic signed [PW-1:0] px;
    logic                in_win;
    logic [RW:0]         ring_tmp;
    logic [RW-1:0]       ring_start;
    logic                r_rd_vld;

    assign two_r = RADW'({r_eff, 1'b0});
    assign py = $signed(PW'(r_y)) - $signed(PW'(r_eff)) + $signed(PW'(r_wi));
    assign px = $signed(PW'(r_x)) - $signed(PW'(r_eff)) + $signed(PW'(r_wj));
    assign in_win = !py[PW-1] && (py < $signed(PW'(h_eff)))
                 && !px[PW-1] && (px < $signed(PW'(w_eff)));
    assign ring_tmp = (RW+1)'(r_y_ring) + (RW+1)'(RING) - (RW+1)'(r_eff);
    assign ring_start = (ring_tmp >= (RW+1)'(RING)) ? RW'(ring_tmp - (RW+1)'(RING))
                                                     : RW'(ring_tmp);

    always_ff @(posedge i_clk) begin
        if (i_cmd_dp.win_start) begin
            r_wi    <= '0;
            r_wj    <= '0;
            r_wring <= ring_start;
        end else if (i_cmd_dp.win_step) begin
            if (r_wj == two_r) begin
                r_wj    <= '0;
                r_wi    <= r_wi + RADW'(1);
                r_wring <= (r_wring == RW'(RING - 1)) ? '0 : r_wring + RW'(1);
            end else begin
                r_wj <= r_wj + RADW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd_dp.win_step && in_win;
        end
    end

    // line store
    logic [AW-1:0] ram_addr;
    logic [23:0]   ram_rdata;

    assign ram_addr = do_write ? AW'({r_wr_ring, r_wr_col})
                               : AW'({r_wring, px[CW-1:0]});

    rbb_ram #(
        .WIDTH(24),
        .DEPTH(RING << CW)
    ) u_line_store (
        .i_clk  (i_clk),
        .i_we   (do_write),
        .i_addr (ram_addr),
        .i_wdata({i_red, i_green, i_blue}),
        .o_rdata(ram_rdata)
    );

    // accumulate, divide, root: one lane per color
    logic [SUM_W-1:0]  r_sum  [3];
    logic [SUM_W-1:0]  r_num  [3];
    logic [AREA_W-1:0] r_rem  [3];
    logic [SQW-1:0]    r_sv   [3];
    logic [SQW-1:0]    r_root [3];
    logic [SQW-1:0]    r_bit;
    logic [DCW-1:0]    r_dcnt;
    logic [SCW-1:0]    r_scnt;
    logic [15:0]       term   [3];
    logic [AREA_W:0]   rem_sh [3];
    logic [SQW-1:0]    trial  [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic [7:0] ch;
            ch = ram_rdata[23 - 8*c -: 8];
            term[c]   = (r_cfg_mode == MODE_RMS) ? 16'(ch) * 16'(ch) : 16'(ch);
            rem_sh[c] = {r_rem[c], r_num[c][SUM_W-1]};
            trial[c]  = r_root[c] + r_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (i_cmd_dp.win_start) begin
                r_sum[c] <= '0;
            end else if (r_rd_vld) begin
                r_sum[c] <= r_sum[c] + SUM_W'(term[c]);
            end
            if (i_cmd_dp.div_start) begin
                r_num[c] <= r_sum[c];
                r_rem[c] <= '0;
            end else if (i_cmd_dp.div_step) begin
                if (rem_sh[c] >= (AREA_W+1)'(area)) begin
                    r_rem[c] <= AREA_W'(rem_sh[c] - (AREA_W+1)'(area));
                    r_num[c] <= {r_num[c][SUM_W-2:0], 1'b1};
                end else begin
                    r_rem[c] <= AREA_W'(rem_sh[c]);
                    r_num[c] <= {r_num[c][SUM_W-2:0], 1'b0};
                end
            end
            if (i_cmd_dp.sq_start) begin
                r_sv[c]   <= SQW'(r_num[c]);
                r_root[c] <= '0;
            end else if (i_cmd_dp.sq_step) begin
                if (r_sv[c] >= trial[c]) begin
                    r_sv[c]   <= r_sv[c] - trial[c];
                    r_root[c] <= (r_root[c] >> 1) + r_bit;
                end else begin
                    r_root[c] <= r_root[c] >> 1;
                end
            end
        end
        if (i_cmd_dp.div_start) begin
            r_dcnt <= DCW'(SUM_W);
        end else if (i_cmd_dp.div_step) begin
            r_dcnt <= r_dcnt - DCW'(1);
        end
        if (i_cmd_dp.sq_start) begin
            r_bit  <= SQW'(1) << (2 * (SQ_STEPS - 1));
            r_scnt <= SCW'(SQ_STEPS);
        end else if (i_cmd_dp.sq_step) begin
            r_bit  <= r_bit >> 2;
            r_scnt <= r_scnt - SCW'(1);
        end
    end

    // output register
    logic       r_out_vld;
    logic [7:0] r_out_px [3];
    logic       r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd_dp.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_dp.emit) begin
            for (int c = 0; c < 3; c++) begin
                r_out_px[c] <= (r_cfg_mode == MODE_RMS) ? r_root[c][7:0] : r_num[c][7:0];
            end
            r_out_last <= is_last;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_out_red    = r_out_px[0];
    assign o_out_green  = r_out_px[1];
    assign o_out_blue   = r_out_px[2];
    assign o_frame_last = r_out_last;

    // status to the sequencer
    assign o_sts.res_ready = (r_out_cnt < total)
        && (full || ({{THR_W{1'b0}}, lead} >= CMP_W'(thr)));
    assign o_sts.win_last  = (r_wi == two_r) && (r_wj == two_r);
    assign o_sts.div_done  = (r_dcnt == '0);
    assign o_sts.sq_done   = (r_scnt == '0);
    assign o_sts.out_busy  = r_out_vld && !i_ready;
    assign o_sts.mode      = r_cfg_mode;

endmodule

// File: rtl/core/rgb_box_blur_stream_unit.sv
// Box blur over an RGB raster stream, top level.
// Instantiates rbb_ctrl and rbb_datapath; depends on rbb_pkg.
//
// Input channel (i_valid/o_ready) carries pixel items (i_cmd pixel) in raster
// order, then drain items to flush the results still owed after the last
// pixel. Output channel (o_valid/i_ready) carries one blurred pixel per
// result, o_frame_last high on the frame's final one. Results trail pixels
// by radius rows plus radius pixels.
// Configuration is written through i_cfg_wr_en/i_cfg_idx/i_cfg_data while
// the block is idle; any write restarts the frame.
// Items are handled one at a time. An item that gives no result only passes
// the check; one that gives a result also goes through the window sum, the
// division and, in root mode, the root. The window is read one pixel per
// cycle from the single-port line store, and the divider and root resolve
// one quotient bit or one root bit per cycle; the quotient is SUM_W bits
// wide, the window sum width (26 with the default radius limit).
// A stalled receiver holds the finished result in the output register; the
// block waits before loading the next result there.
// Reset restores the default configuration and starts a new frame; the line
// store is not cleared, every read hits a pixel of the current frame.
module rgb_box_blur_stream_unit import rbb_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int MAX_RADIUS = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_cmd,
    input  logic [7:0]            i_red,
    input  logic [7:0]            i_green,
    input  logic [7:0]            i_blue,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_out_red,
    output logic [7:0]            o_out_green,
    output logic [7:0]            o_out_blue,
    output logic                  o_frame_last
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    rbb_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_sts  (dp_sts),
        .o_cmd  (dp_cmd)
    );

    rbb_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_RADIUS(MAX_RADIUS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (i_cmd),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_frame_last(o_frame_last),
        .i_cmd_dp    (dp_cmd),
        .o_sts       (dp_sts)
    );

endmodule

// File: verif/rgb_box_blur_stream_unit_test.sv
// Self-checking testbench of rgb_box_blur_stream_unit: directed table, then random frames.
// Table rows or a window-average predictor give expected pixels; depends on rbb_pkg.
module rgb_box_blur_stream_unit_test;
    import rbb_pkg::*;

    localparam int WMAX       = 2048;
    localparam int HMAX       = 2048;
    localparam int RMAX       = 15;
    localparam int RING       = 2 * RMAX + 2;
    localparam int CYCLE_CAP  = 20_000_000;
    localparam int PIXEL_GOAL = 1100;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_pix;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  cmd;
        logic [7:0]            red;
        logic [7:0]            green;
        logic [7:0]            blue;
        logic                  typed;
        t_pix                  exp;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_cmd;
    logic [7:0]            i_red;
    logic [7:0]            i_green;
    logic [7:0]            i_blue;
    logic                  o_valid;
    logic                  i_ready;
    logic [7:0]            o_out_red;
    logic [7:0]            o_out_green;
    logic [7:0]            o_out_blue;
    logic                  o_frame_last;

    rgb_box_blur_stream_unit u_top (.*);

    // predictor state
    logic [23:0]     line_rows [RING][WMAX];
    int unsigned     px_taken;
    int unsigned     px_blurred;
    logic [11:0]     cfg_width;
    logic [11:0]     cfg_height;
    logic [3:0]      cfg_radius;
    logic            cfg_mode;

    t_pix            blurred_q [$];
    int unsigned     n_accepted;
    int unsigned     n_fail;
    int unsigned     n_cycles;
    int unsigned     pixels_sent;
    int              tx_idle;
    int              rx_idle;
    logic            tbl_typed;
    t_pix            tbl_exp;
    t_pix            got;
    t_pix            want;
    logic            want_any;

    function automatic int unsigned eff_width();
        if (cfg_width == 0) return 1;
        return (cfg_width > WMAX) ? WMAX : cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        if (cfg_height == 0) return 1;
        return (cfg_height > HMAX) ? HMAX : cfg_height;
    endfunction

    function automatic int unsigned eff_radius();
        return (cfg_radius > RMAX) ? RMAX : cfg_radius;
    endfunction

    function automatic logic [7:0] reduce_sum(input int unsigned sum, input int unsigned area);
        int unsigned q;
        int unsigned root;
        q = sum / area;
        if (cfg_mode == MODE_RMS) begin
            root = 0;
            for (int b = 7; b >= 0; b--) begin
                if (((root | (1 << b)) * (root | (1 << b))) <= q) root = root | (1 << b);
            end
            q = root;
        end
        return q[7:0];
    endfunction

    // one accepted item: store the pixel, then emit the next window average if it is due
    function automatic void blur_step(input logic cmd, input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b, output logic has, output t_pix res);
        int unsigned w, h, rad, total, m, x, y, area, sr, sg, sb, cr, cg, cb;
        int          py, px;
        logic [23:0] p;
        w = eff_width();
        h = eff_height();
        rad = eff_radius();
        total = w * h;
        has = 1'b0;
        res = '0;
        sr = 0;
        sg = 0;
        sb = 0;
        if (cmd == CMD_PIXEL && px_taken < total) begin
            line_rows[(px_taken / w) % RING][px_taken % w] = {r, g, b};
            px_taken++;
        end else if (px_taken < total) begin
            return;
        end
        m = px_blurred;
        if (m >= total) return;
        if (!(px_taken >= total || px_taken >= m + rad * w + rad + 1)) return;
        y = m / w;
        x = m % w;
        for (int dy = -int'(rad); dy <= int'(rad); dy++) begin
            py = int'(y) + dy;
            if (py < 0 || py >= int'(h)) continue;
            for (int dx = -int'(rad); dx <= int'(rad); dx++) begin
                px = int'(x) + dx;
                if (px < 0 || px >= int'(w)) continue;
                p = line_rows[py % RING][px];
                cr = p[23:16];
                cg = p[15:8];
                cb = p[7:0];
                if (cfg_mode == MODE_RMS) begin
                    cr = cr * cr;
                    cg = cg * cg;
                    cb = cb * cb;
                end
                sr += cr;
                sg += cg;
                sb += cb;
            end
        end
        area = (2 * rad + 1) * (2 * rad + 1);
        res.red = reduce_sum(sr, area);
        res.green = reduce_sum(sg, area);
        res.blue = reduce_sum(sb, area);
        if (m == total - 1) begin
            res.last = 1'b1;
            px_taken = 0;
            px_blurred = 0;
        end else begin
            px_blurred = m + 1;
        end
        has = 1'b1;
    endfunction

    function automatic void check_field(input string name, input int e, input int a);
        if (e != a) begin
            $error("%s mismatch: expected %0d, actual %0d", name, e, a);
            n_fail++;
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(negedge i_clk) i_ready <= ($urandom_range(0, 99) >= rx_idle);

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_CAP) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // scoreboard and predictor update, on pre-edge values
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            px_taken = 0;
            px_blurred = 0;
            cfg_width = RST_FRAME_WIDTH;
            cfg_height = RST_FRAME_HEIGHT;
            cfg_radius = RST_RADIUS;
            cfg_mode = RST_MODE;
        end else begin
            if (o_valid && i_ready) begin
                if (blurred_q.size() == 0) begin
                    $error("result with no expectation waiting");
                    n_fail++;
                end else begin
                    got = blurred_q.pop_front();
                    check_field("out_red", got.red, o_out_red);
                    check_field("out_green", got.green, o_out_green);
                    check_field("out_blue", got.blue, o_out_blue);
                    check_field("frame_last", got.last, o_frame_last);
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_FRAME_WIDTH:  cfg_width = i_cfg_data;
                    CFG_FRAME_HEIGHT: cfg_height = i_cfg_data;
                    CFG_RADIUS:       cfg_radius = i_cfg_data[3:0];
                    CFG_MODE:         cfg_mode = i_cfg_data[0];
                    default: ;
                endcase
                px_taken = 0;
                px_blurred = 0;
            end
            if (i_valid && o_ready) begin
                n_accepted++;
                blur_step(i_cmd, i_red, i_green, i_blue, want_any, want);
                if (tbl_typed) blurred_q.push_back(tbl_exp);
                else if (want_any) blurred_q.push_back(want);
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic typed, input t_pix exp);
        int unsigned seen;
        seen = n_accepted;
        tbl_typed = typed;
        tbl_exp = exp;
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        do @(negedge i_clk); while (n_accepted == seen);
        tbl_typed = 1'b0;
        // count every transfer, drains included
        pixels_sent++;
        if (pixels_sent == PIXEL_GOAL / 3) begin
            tx_idle = 74;
            rx_idle = 35;
        end else if (pixels_sent == 2 * PIXEL_GOAL / 3) begin
            tx_idle = 0;
            rx_idle = 0;
        end
        if ($urandom_range(0, 99) < tx_idle) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    // hold off until every owed result is out and the window engine has settled
    task automatic wait_idle();
        int unsigned side;
        i_valid <= 1'b0;
        while (blurred_q.size() != 0) @(negedge i_clk);
        side = 2 * eff_radius() + 1;
        repeat (side * side + 64) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    t_row dir_rows [0:49];

    initial begin
        int unsigned w, h, rad, total, cut, pick, frame_no;
        logic        broken;
        t_pix        nul;
        nul = '0;
        dir_rows = '{
            // default 1280x720 frame: an early drain is dropped, pixels give nothing yet
            '{1'b0, CFG_MODE, 12'd0, CMD_DRAIN, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, '0},
            '{1'b1, CFG_FRAME_WIDTH, 12'd1, CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b1, CFG_FRAME_HEIGHT, 12'd1, CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b1, CFG_RADIUS, 12'd0, CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b1, CFG_MODE, {11'd0, MODE_MEAN}, CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            // single-pixel frames pass the pixel through
            '{1'b0, CFG_MODE, 12'd0, CMD_PIXEL, 8'd255, 8'd0, 8'd128, 1'b1,
              '{8'd255, 8'd0, 8'd128, 1'b1}},
            '{1'b0, CFG_MODE, 12'd0, CMD_PIXEL, 8'd0, 8'd255, 8'd1, 1'b1,
              '{8'd0, 8'd255, 8'd1, 1'b1}},
            '{1'b0, CFG_MODE, 12'd0, CMD_DRAIN, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b1, CFG_MODE, {11'd0, MODE_RMS}, CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_PIXEL, 8'd255, 8'd17, 8'd0, 1'b1,
              '{8'd255, 8'd17, 8'd0, 1'b1}},
            // zero sizes act as one
            '{1'b1, CFG_FRAME_WIDTH, 12'd0, CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b1, CFG_FRAME_HEIGHT, 12'd0, CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_PIXEL, 8'd7, 8'd8, 8'd9, 1'b1,
              '{8'd7, 8'd8, 8'd9, 1'b1}},
            // 3x2 mean, radius 1: early drain dropped, surplus pixel acts as drain
            '{1'b1, CFG_FRAME_WIDTH, 12'd3, CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b1, CFG_FRAME_HEIGHT, 12'd2, CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b1, CFG_RADIUS, 12'd1, CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b1, CFG_MODE, {11'd0, MODE_MEAN}, CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_PIXEL, 8'd0, 8'd128, 8'd255, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_PIXEL, 8'd1, 8'd2, 8'd3, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_DRAIN, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_PIXEL, 8'd255, 8'd0, 8'd0, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_PIXEL, 8'd9, 8'd9, 8'd9, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_PIXEL, 8'd200, 8'd100, 8'd50, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_DRAIN, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_PIXEL, 8'd77, 8'd77, 8'd77, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_DRAIN, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_DRAIN, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            // 2x2 root mode at the largest radius
            '{1'b1, CFG_FRAME_WIDTH, 12'd2, CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b1, CFG_FRAME_HEIGHT, 12'd2, CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b1, CFG_RADIUS, 12'd15, CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b1, CFG_MODE, {11'd0, MODE_RMS}, CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_PIXEL, 8'd255, 8'd0, 8'd255, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_PIXEL, 8'd128, 8'd64, 8'd32, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_DRAIN, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_DRAIN, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_DRAIN, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            // oversize registers clamp to the maximum; frames left open
            '{1'b1, CFG_FRAME_WIDTH, 12'd4095, CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b1, CFG_FRAME_HEIGHT, 12'd1, CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b1, CFG_RADIUS, 12'd0, CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_PIXEL, 8'd170, 8'd85, 8'd15, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_PIXEL, 8'd240, 8'd3, 8'd254, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_PIXEL, 8'd1, 8'd128, 8'd127, 1'b0, '0},
            '{1'b1, CFG_FRAME_WIDTH, 12'd1, CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b1, CFG_FRAME_HEIGHT, 12'd4095, CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_PIXEL, 8'd33, 8'd66, 8'd99, 1'b0, '0},
            '{1'b0, CFG_MODE, 12'd0, CMD_PIXEL, 8'd254, 8'd253, 8'd252, 1'b0, '0}
        };

        n_accepted = 0;
        n_fail = 0;
        n_cycles = 0;
        pixels_sent = 0;
        tx_idle = 35;
        rx_idle = 74;
        tbl_typed = 1'b0;
        tbl_exp = '0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_cmd = CMD_PIXEL;
        i_red = '0;
        i_green = '0;
        i_blue = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) begin
                wait_idle();
                write_cfg(dir_rows[k].idx, dir_rows[k].data);
            end else begin
                send_item(dir_rows[k].cmd, dir_rows[k].red, dir_rows[k].green,
                          dir_rows[k].blue, dir_rows[k].typed, dir_rows[k].exp);
            end
        end

        frame_no = 0;
        broken = 1'b1;
        while (pixels_sent < PIXEL_GOAL) begin
            // reuse the current setting now and then, back to back
            if (broken || $urandom_range(0, 4) != 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    rad = $urandom_range(0, 2);
                    w = $urandom_range(1, 12);
                    h = $urandom_range(1, 8);
                end else if (pick < 90) begin
                    rad = $urandom_range(3, 6);
                    w = $urandom_range(1, 40);
                    h = $urandom_range(1, 6);
                end else begin
                    rad = $urandom_range(7, 15);
                    w = $urandom_range(1, 4);
                    h = $urandom_range(1, 4);
                end
                wait_idle();
                write_cfg(CFG_FRAME_WIDTH, w[11:0]);
                write_cfg(CFG_FRAME_HEIGHT, h[11:0]);
                write_cfg(CFG_RADIUS, rad[11:0]);
                write_cfg(CFG_MODE, 12'($urandom_range(0, 1)));
            end
            total = eff_width() * eff_height();
            broken = ($urandom_range(0, 7) == 0);
            cut = broken ? $urandom_range(0, total - 1) : total;
            for (int unsigned n = 0; n < cut; n++) begin
                if ($urandom_range(0, 19) == 0)
                    send_item(CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, nul);
                // sender waits for the block to catch up mid frame
                if (frame_no == 3 && n == cut / 2) wait_idle();
                send_item(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, nul);
            end
            if (!broken) begin
                while (px_taken != 0) begin
                    if ($urandom_range(0, 2) == 0)
                        send_item(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, nul);
                    else
                        send_item(CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, nul);
                end
            end
            frame_no++;
        end

        wait_idle();
        if (n_fail == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/rbb_pkg.sv
rtl/core/rbb_ram.sv
rtl/core/rbb_ctrl.sv
rtl/core/rbb_datapath.sv
rtl/core/rgb_box_blur_stream_unit.sv
verif/rgb_box_blur_stream_unit_test.sv
